// ----- src/sample_voice_player_core_defines.svh -----
// assertion macros for the sample voice player checker
// no dependencies
`ifndef SAMPLE_VOICE_PLAYER_CORE_DEFINES_SVH
`define SAMPLE_VOICE_PLAYER_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SVP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define SVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/svp_pkg.sv -----
// shared types, constants and helpers for the sample voice player
// no dependencies
`timescale 1ns / 1ps
package svp_pkg;
  localparam int AddrBits = 14;
  localparam int FracBits = 16;
  localparam int PosBits = AddrBits + FracBits + 2;
  localparam int StoreDepth = 1 << AddrBits;
  localparam int FadeUnity = 65536;

  typedef enum logic [2:0] {
    REQ_LOAD = 3'd0, REQ_START = 3'd1, REQ_RELEASE = 3'd2,
    REQ_STEAL = 3'd3, REQ_TICK = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CFG_COUNT = 3'd0, CFG_FADE_IN = 3'd1, CFG_RELEASE = 3'd2,
    CFG_STEAL = 3'd3, CFG_FADE_TIME = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RDW,
    ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_OUT
  } st_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [13:0] load_address;
    logic signed [15:0] load_left;
    logic signed [15:0] load_right;
    logic [13:0] region_start;
    logic [14:0] region_end;
    logic        play_reverse;
    logic [23:0] pitch_step;
    logic [15:0] note_gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic voice_active;
    logic voice_ended;
  } out_item_t;

  // read and write request from the sequencer to the store
  typedef struct packed {
    logic                rd_en;
    logic [AddrBits-1:0] rd_addr;
    logic                wr_en;
    logic [AddrBits-1:0] wr_addr;
    logic [31:0]         wr_data;
  } mem_req_t;

  function automatic logic [16:0] clamp_step(input logic [16:0] v);
    if (v == 17'd0) return 17'd1;
    if (v > 17'(FadeUnity)) return 17'(FadeUnity);
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction
endpackage

// ----- src/svp_if.sv -----
// valid/ready channel carrying a payload of type T
// no dependencies; the payload type is a parameter
`timescale 1ns / 1ps
interface svp_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/svp_store.sv -----
// stereo sample store, one write and one registered read port
// depends on svp_pkg
`timescale 1ns / 1ps
module svp_store (
  input  logic clk,
  input  svp_pkg::mem_req_t req,
  output logic [31:0] rd_data
);
  import svp_pkg::*;
  logic [31:0] mem [StoreDepth];
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end
endmodule

// ----- src/svp_seq.sv -----
// voice sequencer: control state, fade, store reads and cubic datapath
// depends on svp_pkg and the svp_store read data
`timescale 1ns / 1ps
module svp_seq (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  svp_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output svp_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [16:0] cfg_wdata,
  output svp_pkg::mem_req_t mreq,
  input  logic [31:0] rd_data
);
  import svp_pkg::*;

  st_t st_r, st_nxt;
  logic [14:0] cnt_r;
  logic [16:0] fin_r, rel_r, stl_r;
  logic [15:0] ftime_r;

  logic [PosBits-1:0] pos_r;
  logic [13:0] first_r;
  logic [14:0] limit_r;
  logic rev_r, fout_r, act_r;
  logic [23:0] step_r;
  logic [15:0] gain_r;
  logic [17:0] lvl_r;
  logic signed [17:0] delta_r;

  logic [AddrBits-1:0] idx_r [4];
  logic signed [15:0] yl_r [4], yr_r [4];
  logic [1:0] rcnt_r;
  logic [FracBits-1:0] f_r;
  logic signed [32:0] g_r;
  logic signed [23:0] pl_r, pr_r, bl_r, br_r, cl_r, cr_r;
  logic signed [17:0] vl_r, vr_r;
  logic signed [39:0] ol_r, or_r;
  logic obuf_v_r;
  out_item_t obuf_r;
  logic ovld_r;

  // effective count
  logic [14:0] ceff;
  assign ceff = (cnt_r == 15'd0) ? 15'd1 : (cnt_r > 15'(StoreDepth) ? 15'(StoreDepth) : cnt_r);

  logic acc;
  assign in_ready = (st_r == ST_IDLE) && !obuf_v_r;
  assign acc = in_valid && in_ready;
  assign out_valid = obuf_v_r;
  assign out_data = obuf_r;

  // tick preamble computed combinationally from state
  logic [PosBits-1:0] lo, hi;
  logic oob;
  logic signed [18:0] lvl_sum;
  assign lo = PosBits'(first_r) << FracBits;
  assign hi = PosBits'(limit_r) << FracBits;
  assign oob = (pos_r < lo) || (pos_r >= hi);
  assign lvl_sum = $signed({1'b0, lvl_r}) + 19'(delta_r);

  logic [14:0] lim_c;
  assign lim_c = (in_data.region_end > ceff) ? ceff : in_data.region_end;

  logic [14:0] last;
  logic [AddrBits:0] i1c;
  assign last = ceff - 15'd1;
  assign i1c = (pos_r[PosBits-1:FracBits] > 16'(last)) ? last[AddrBits:0]
               : pos_r[FracBits+AddrBits:FracBits];

  logic [PosBits-1:0] rem;
  logic [39:0] flim;
  assign rem = rev_r ? pos_r - lo : hi - pos_r;
  assign flim = ftime_r * step_r;

  // unsigned gain product, below 2^32
  logic [31:0] gprod;
  assign gprod = gain_r * lvl_r[16:0];

  // datapath helpers
  logic signed [17:0] y0l, y1l, y2l, y3l, y0r, y1r, y2r, y3r;
  assign y0l = 18'(yl_r[0]); assign y1l = 18'(yl_r[1]);
  assign y2l = 18'(yl_r[2]); assign y3l = 18'(yl_r[3]);
  assign y0r = 18'(yr_r[0]); assign y1r = 18'(yr_r[1]);
  assign y2r = 18'(yr_r[2]); assign y3r = 18'(yr_r[3]);
  logic signed [41:0] ml, mr;
  assign ml = 42'(pl_r) * $signed({1'b0, f_r});
  assign mr = 42'(pr_r) * $signed({1'b0, f_r});
  logic signed [50:0] gl, gr;
  assign gl = 51'(vl_r) * 51'(g_r);
  assign gr = 51'(vr_r) * 51'(g_r);
  logic signed [23:0] hl, hr;
  assign hl = 24'(pl_r + 24'sd1) >>> 1;
  assign hr = 24'(pr_r + 24'sd1) >>> 1;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc && in_data.req_type == REQ_TICK && act_r && !oob
                   && !(delta_r < 0 && lvl_sum <= 0)) st_nxt = ST_RD0;
      ST_RD0: st_nxt = ST_RD1;
      ST_RD1: st_nxt = ST_RD2;
      ST_RD2: st_nxt = ST_RD3;
      ST_RD3: st_nxt = ST_RDW;
      ST_RDW: st_nxt = ST_C1;
      ST_C1: st_nxt = ST_C2;
      ST_C2: st_nxt = ST_C3;
      ST_C3: st_nxt = ST_C4;
      ST_C4: st_nxt = ST_C5;
      ST_C5: st_nxt = ST_C6;
      ST_C6: st_nxt = ST_OUT;
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mreq = '0;
    mreq.wr_en = acc && in_data.req_type == REQ_LOAD;
    mreq.wr_addr = in_data.load_address;
    mreq.wr_data = {in_data.load_right, in_data.load_left};
    mreq.rd_en = (st_r == ST_RD0) || (st_r == ST_RD1) || (st_r == ST_RD2) || (st_r == ST_RD3);
    mreq.rd_addr = idx_r[rcnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= 15'd16384; fin_r <= 17'd455; rel_r <= 17'd455;
      stl_r <= 17'd1365; ftime_r <= 16'd144;
      pos_r <= '0; first_r <= '0; limit_r <= '0; rev_r <= 1'b0;
      step_r <= '0; gain_r <= '0; lvl_r <= '0; delta_r <= '0;
      fout_r <= 1'b0; act_r <= 1'b0; obuf_v_r <= 1'b0; rcnt_r <= '0; ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (obuf_v_r && out_ready) obuf_v_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT: cnt_r <= cfg_wdata[14:0];
          CFG_FADE_IN: fin_r <= cfg_wdata;
          CFG_RELEASE: rel_r <= cfg_wdata;
          CFG_STEAL: stl_r <= cfg_wdata;
          CFG_FADE_TIME: ftime_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (acc) begin
        case (in_data.req_type)
          REQ_START: if (lim_c > 15'(in_data.region_start)) begin
            first_r <= in_data.region_start; limit_r <= lim_c;
            rev_r <= in_data.play_reverse; step_r <= in_data.pitch_step;
            gain_r <= in_data.note_gain;
            pos_r <= PosBits'(in_data.play_reverse ? lim_c - 15'd1
                              : 15'(in_data.region_start)) << FracBits;
            lvl_r <= '0; delta_r <= 18'(clamp_step(fin_r));
            fout_r <= 1'b0; act_r <= 1'b1;
          end
          REQ_RELEASE, REQ_STEAL: if (act_r) begin
            fout_r <= 1'b1;
            delta_r <= -18'(clamp_step(in_data.req_type == REQ_RELEASE ? rel_r : stl_r));
          end
          REQ_TICK: begin
            if (!act_r) begin
              obuf_v_r <= 1'b1; obuf_r <= '0;
            end else if (oob || (delta_r < 0 && lvl_sum <= 0)) begin
              act_r <= 1'b0; obuf_v_r <= 1'b1;
              obuf_r <= '{left_out: '0, right_out: '0, voice_active: 1'b0,
                          voice_ended: 1'b1};
              if (!oob) lvl_r <= '0;
            end else begin
              if (delta_r > 0 && lvl_sum >= 19'sd65536) lvl_r <= 18'd65536;
              else lvl_r <= lvl_sum[17:0];
              // auto-release near the region end overrides the fade-in stop
              if (!fout_r && 40'(rem) <= flim) begin
                fout_r <= 1'b1; delta_r <= -18'(clamp_step(rel_r));
              end else if (delta_r > 0 && lvl_sum >= 19'sd65536) delta_r <= '0;
              f_r <= pos_r[FracBits-1:0];
              idx_r[1] <= i1c[AddrBits-1:0];
              idx_r[0] <= (i1c == '0) ? '0 : AddrBits'(i1c - 1'b1);
              idx_r[2] <= (15'(i1c) + 15'd1 > last) ? last[AddrBits-1:0]
                          : AddrBits'(i1c + 1'b1);
              idx_r[3] <= (15'(i1c) + 15'd2 > last) ? last[AddrBits-1:0]
                          : AddrBits'(i1c + 2'd2);
              rcnt_r <= '0;
            end
          end
          default: ;
        endcase
      end
      // gain uses the already updated fade level
      if (st_r == ST_RD0) g_r <= $signed({1'b0, gprod});
      if (mreq.rd_en) rcnt_r <= rcnt_r + 2'd1;
      ovld_r <= mreq.rd_en;
      if (ovld_r) begin
        yl_r[0] <= yl_r[1]; yl_r[1] <= yl_r[2]; yl_r[2] <= yl_r[3]; yl_r[3] <= rd_data[15:0];
        yr_r[0] <= yr_r[1]; yr_r[1] <= yr_r[2]; yr_r[2] <= yr_r[3]; yr_r[3] <= rd_data[31:16];
      end
      unique case (st_r)
        ST_C1: begin
          pl_r <= 24'(3 * (y1l - y2l) - y0l + y3l);
          pr_r <= 24'(3 * (y1r - y2r) - y0r + y3r);
          bl_r <= 24'(4 * y2l + 2 * y0l - 5 * y1l - y3l);
          br_r <= 24'(4 * y2r + 2 * y0r - 5 * y1r - y3r);
          cl_r <= 24'(y2l - y0l); cr_r <= 24'(y2r - y0r);
        end
        ST_C2: begin
          pl_r <= 24'(ml >>> FracBits) + bl_r; pr_r <= 24'(mr >>> FracBits) + br_r;
        end
        ST_C3: begin
          pl_r <= 24'(ml >>> FracBits) + cl_r; pr_r <= 24'(mr >>> FracBits) + cr_r;
        end
        ST_C4: begin
          pl_r <= 24'(ml >>> FracBits); pr_r <= 24'(mr >>> FracBits);
        end
        ST_C5: begin
          vl_r <= 18'(y1l + 18'(hl)); vr_r <= 18'(y1r + 18'(hr));
        end
        ST_C6: begin
          ol_r <= 40'((gl + 51'sd536870912) >>> 30);
          or_r <= 40'((gr + 51'sd536870912) >>> 30);
        end
        ST_OUT: begin
          obuf_v_r <= 1'b1;
          obuf_r.left_out <= sat16(ol_r); obuf_r.right_out <= sat16(or_r);
          obuf_r.voice_active <= 1'b1; obuf_r.voice_ended <= 1'b0;
          if (rev_r) pos_r <= (PosBits'(step_r) > pos_r) ? '1 : pos_r - PosBits'(step_r);
          else pos_r <= ({1'b0, pos_r} + (PosBits+1)'(step_r) > {1'b0, {PosBits{1'b1}}})
                        ? '1 : pos_r + PosBits'(step_r);
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- src/sample_voice_player_core.sv -----
// top level of the stereo sample voice player
// depends on svp_pkg, svp_if, svp_store and svp_seq
`timescale 1ns / 1ps
// channel | dir | transfer carries
// in_     | in  | load, start, release, steal or tick request
// out_    | out | one stereo frame per tick request
// cfg_    | in  | register write, index and data
// a tick that sounds runs through its states after its transfer, before the next
// request is taken: four store reads, then the cubic and gain, one stage per cycle with
// left and right in parallel; a silent tick writes its frame at its transfer, other requests take effect at theirs
// reset is synchronous and restores the register defaults; store contents
// stay undefined until loaded
// a result waits in the output register; the next request is held off until
// it has been transferred
module sample_voice_player_core (
  input logic clk,
  input logic rst_n,
  svp_if.sink in_ch,
  svp_if.source out_ch,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [16:0] cfg_wdata
);
  import svp_pkg::*;
  mem_req_t mreq;
  logic [31:0] rd_data;

  // sample store holds the loaded stereo frames
  svp_store u_store (.clk(clk), .req(mreq), .rd_data(rd_data));

  // sequencer runs the voice state and interpolation
  svp_seq u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mreq(mreq), .rd_data(rd_data)
  );
endmodule

// ----- src/svp_checker.sv -----
// port-level checker for the sample voice player, bound to the top level
// depends on the defines header
`timescale 1ns / 1ps
`include "sample_voice_player_core_defines.svh"
module svp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic active,
  input logic ended
);
  `SVP_ASSERT_IMPL(a_not_both, clk, rst_n, out_valid, !(active && ended), "active and ended")
  `SVP_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, !in_ready, "input ready with result pending")
  `SVP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind sample_voice_player_core svp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .active(out_ch.data.voice_active), .ended(out_ch.data.voice_ended)
);

// ----- tb/sv/svp_tb_checker.sv -----
// checker for the sample voice player: watches both channels, predicts each tick frame
// depends on svp_pkg and svp_if
`timescale 1ns / 1ps
module svp_tb_checker (
  input logic clk,
  input logic rst_n,
  svp_if.sink in_mon,
  svp_if.sink out_mon,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [16:0] cfg_wdata,
  output int fail_count,
  output int frames_pending
);
  import svp_pkg::*;

  localparam longint PosMask = (64'd1 << PosBits) - 1;

  logic [31:0] store_m [StoreDepth];
  longint unsigned pos_m;
  int unsigned first_m, limit_m, rev_m, step_m, gain_m;
  int fade_m, delta_m;
  bit fading_m, active_m;
  int unsigned count_r, fade_in_r, release_r, steal_r, fade_time_r;
  out_item_t frame_q[$];

  assign frames_pending = frame_q.size();

  function automatic longint fl_shift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic int step_lim(int unsigned v);
    if (v < 1) return 1;
    if (v > FadeUnity) return FadeUnity;
    return int'(v);
  endfunction

  function automatic int unsigned count_used();
    if (count_r > StoreDepth) return StoreDepth;
    if (count_r < 1) return 1;
    return count_r;
  endfunction

  function automatic longint chan_val(int unsigned idx, bit right);
    logic [31:0] w;
    w = store_m[idx % StoreDepth];
    return right ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
  endfunction

  function automatic longint catmull(int unsigned i1, int unsigned f, bit right);
    int unsigned last, i0, i2, i3;
    longint y0, y1, y2, y3, a, b, c, p;
    last = count_used() - 1;
    if (i1 > last) i1 = last;
    i0 = (i1 > 0) ? i1 - 1 : 0;
    i2 = (i1 + 1 > last) ? last : i1 + 1;
    i3 = (i1 + 2 > last) ? last : i1 + 2;
    y0 = chan_val(i0, right); y1 = chan_val(i1, right);
    y2 = chan_val(i2, right); y3 = chan_val(i3, right);
    a = 3 * (y1 - y2) - y0 + y3;
    b = 4 * y2 + 2 * y0 - 5 * y1 - y3;
    c = y2 - y0;
    p = fl_shift(a * longint'(f), FracBits) + b;
    p = fl_shift(p * longint'(f), FracBits) + c;
    p = fl_shift(p * longint'(f), FracBits);
    return y1 + fl_shift(p + 1, 1);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // advance the voice model by one request; a tick pushes its frame
  task automatic voice_model(in_item_t it);
    out_item_t o;
    int unsigned lim;
    longint unsigned lo, hi, remaining, fade_dist;
    longint g;
    o = '0;
    case (it.req_type)
      REQ_LOAD: store_m[it.load_address] = {it.load_right, it.load_left};
      REQ_START: begin
        lim = it.region_end;
        if (lim > count_used()) lim = count_used();
        if (lim > it.region_start) begin
          first_m = it.region_start; limit_m = lim; rev_m = it.play_reverse;
          step_m = it.pitch_step; gain_m = it.note_gain;
          pos_m = (longint'(rev_m ? lim - 1 : first_m) << FracBits) & PosMask;
          fade_m = 0; delta_m = step_lim(fade_in_r);
          fading_m = 0; active_m = 1;
        end
      end
      REQ_RELEASE, REQ_STEAL: if (active_m) begin
        fading_m = 1;
        delta_m = -step_lim(it.req_type == REQ_RELEASE ? release_r : steal_r);
      end
      REQ_TICK: begin
        if (active_m) begin
          lo = longint'(first_m) << FracBits;
          hi = longint'(limit_m) << FracBits;
          if (pos_m < lo || pos_m >= hi) begin
            active_m = 0; o.voice_ended = 1;
          end else begin
            fade_m += delta_m;
            if (delta_m > 0 && fade_m >= FadeUnity) begin
              fade_m = FadeUnity; delta_m = 0;
            end else if (delta_m < 0 && fade_m <= 0) begin
              fade_m = 0; active_m = 0; o.voice_ended = 1;
            end
            if (active_m) begin
              if (!fading_m) begin
                remaining = rev_m ? pos_m - lo : hi - pos_m;
                fade_dist = longint'(fade_time_r) * longint'(step_m);
                if (remaining <= fade_dist) begin
                  fading_m = 1; delta_m = -step_lim(release_r);
                end
              end
              g = longint'(gain_m) * longint'(fade_m);
              o.left_out = clip16(fl_shift(catmull(pos_m >> FracBits,
                pos_m[FracBits-1:0], 0) * g + (64'sd1 <<< 29), 30));
              o.right_out = clip16(fl_shift(catmull(pos_m >> FracBits,
                pos_m[FracBits-1:0], 1) * g + (64'sd1 <<< 29), 30));
              o.voice_active = 1;
              if (rev_m) begin
                if (step_m > pos_m) pos_m = PosMask;
                else pos_m -= step_m;
              end else begin
                pos_m += step_m;
                if (pos_m > PosMask) pos_m = PosMask;
              end
            end
          end
        end
        frame_q.push_back(o);
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t e, g;
    if (!rst_n) begin
      pos_m <= 0; first_m <= 0; limit_m <= 0; rev_m <= 0; step_m <= 0;
      gain_m <= 0; fade_m <= 0; delta_m <= 0; fading_m <= 0; active_m <= 0;
      count_r <= 16384; fade_in_r <= 455; release_r <= 455;
      steal_r <= 1365; fade_time_r <= 144;
      fail_count <= 0;
      frame_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT: count_r = cfg_wdata[14:0];
          CFG_FADE_IN: fade_in_r = cfg_wdata;
          CFG_RELEASE: release_r = cfg_wdata;
          CFG_STEAL: steal_r = cfg_wdata;
          CFG_FADE_TIME: fade_time_r = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) voice_model(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        g = out_mon.data;
        if (frame_q.size() == 0) report("unexpected frame", 1, 0);
        else begin
          e = frame_q.pop_front();
          if (g.left_out !== e.left_out) report("left_out", g.left_out, e.left_out);
          if (g.right_out !== e.right_out) report("right_out", g.right_out, e.right_out);
          if (g.voice_active !== e.voice_active)
            report("voice_active", g.voice_active, e.voice_active);
          if (g.voice_ended !== e.voice_ended)
            report("voice_ended", g.voice_ended, e.voice_ended);
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_sample_voice_player_core.sv -----
// testbench top for sample_voice_player_core: stimulus, register phases and verdict
// depends on svp_pkg, svp_if, svp_tb_checker and the block itself
`timescale 1ns / 1ps
module tb_sample_voice_player_core;
  import svp_pkg::*;

  // request code outside the defined set
  localparam logic [2:0] ReqUnused = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [16:0] cfg_wdata;
  int fail_count;
  int frames_pending;
  int hold_cycles;     // long receiver hold-off, counted in its own process
  bit stall_enable;    // random receiver stalls on or off
  int loaded_len;      // store frames written so far, from index zero

  svp_if #(in_item_t) in_ch (clk);
  svp_if #(out_item_t) out_ch (clk);

  sample_voice_player_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  svp_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .frames_pending(frames_pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // generous time limit: ~650 items, stalls and gaps included
  initial begin
    #20ms;
    $display("** sample_voice_player_core: FAILED **");
    $finish;
  end

  // no gap mostly, a short one often, a long one now and then
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver: random stalls, or a long counted hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_enable) out_ch.ready <= (gap_len() == 0);
      else out_ch.ready <= 1'b1;
    end
  end

  // one transfer on the request channel, with a random gap ahead;
  // valid stays up afterwards until the next gap or settle
  task automatic send(in_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // registers change only while the block is idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic load_frame(int addr, logic [15:0] l, logic [15:0] r);
    in_item_t it;
    it = rand_item();
    it.req_type = REQ_LOAD;
    it.load_address = 14'(addr);
    it.load_left = l;
    it.load_right = r;
    send(it);
    if (addr >= loaded_len) loaded_len = addr + 1;
  endtask

  // start within the loaded frames; region end may overshoot the count
  task automatic start_note(int s, int e, bit rev, logic [23:0] stp, logic [15:0] gn);
    in_item_t it;
    it = rand_item();
    it.req_type = REQ_START;
    it.region_start = 14'(s);
    it.region_end = 15'(e);
    it.play_reverse = rev;
    it.pitch_step = stp;
    it.note_gain = gn;
    send(it);
  endtask

  task automatic req_only(req_t r);
    in_item_t it;
    it = rand_item();
    it.req_type = r;
    send(it);
  endtask

  initial begin
    in_item_t it;
    int n, s, e;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    hold_cycles = 0;
    stall_enable = 1'b0;
    loaded_len = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small loaded length keeps every store read on written frames
    cfg_write(CFG_COUNT, 17'd32);
    for (int i = 0; i < 32; i++)
      load_frame(i, (i % 3 == 0) ? 16'h7fff : ((i % 3 == 1) ? 16'h8000 : 16'($urandom)),
                 16'($urandom));

    // directed: idle tick, release and steal while idle, unknown request
    req_only(REQ_TICK);
    req_only(REQ_RELEASE);
    req_only(REQ_STEAL);
    it = rand_item(); it.req_type = ReqUnused; send(it);
    // empty region is ignored, region end past count is clamped
    start_note(10, 10, 0, 24'h010000, 16'hffff);
    start_note(0, 16'h7fff, 0, 24'h00c000, 16'hffff);
    repeat (4) req_only(REQ_TICK);
    req_only(REQ_STEAL);
    repeat (3) req_only(REQ_TICK);
    // reverse past the start, huge step, zero step with release
    start_note(2, 8, 1, 24'hffffff, 16'h0000);
    repeat (3) req_only(REQ_TICK);
    start_note(30, 32, 0, 24'hffffff, 16'hffff);
    repeat (3) req_only(REQ_TICK);
    start_note(5, 20, 0, 24'h000000, 16'h4000);
    req_only(REQ_RELEASE);
    repeat (2) req_only(REQ_TICK);
    settle();

    // phases of register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          cfg_write(CFG_FADE_IN, 17'd65536); cfg_write(CFG_RELEASE, 17'd1);
          cfg_write(CFG_STEAL, 17'd65536); cfg_write(CFG_FADE_TIME, 17'd1);
          cfg_write(CFG_COUNT, 17'd1);
        end
        1: begin
          cfg_write(CFG_FADE_IN, 17'd0); cfg_write(CFG_RELEASE, 17'h1ffff);
          cfg_write(CFG_STEAL, 17'd0); cfg_write(CFG_FADE_TIME, 17'd65535);
          cfg_write(CFG_COUNT, 17'd32);
        end
        2: begin
          cfg_write(CFG_FADE_IN, 17'd8000); cfg_write(CFG_RELEASE, 17'd3000);
          cfg_write(CFG_STEAL, 17'd20000); cfg_write(CFG_FADE_TIME, 17'd4);
          cfg_write(CFG_COUNT, 17'd64);
          for (int i = 32; i < 64; i++) load_frame(i, 16'($urandom), 16'($urandom));
        end
        default: begin
          cfg_write(CFG_FADE_IN, 17'd30000); cfg_write(CFG_RELEASE, 17'd455);
          cfg_write(CFG_STEAL, 17'd1365); cfg_write(CFG_FADE_TIME, 17'd144);
          cfg_write(CFG_COUNT, 17'd64);
        end
      endcase
      stall_enable = (ph != 1);
      // long hold-off while requests keep coming
      if (ph == 2) hold_cycles = 300;
      n = 0;
      while (n < 150) begin
        s = $urandom_range(0, 63);
        e = s + $urandom_range(0, 40);
        if ($urandom_range(0, 9) == 0) e = $urandom_range(0, 32767);
        start_note(s, e, $urandom_range(0, 1),
                   ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3 << 16)),
                   16'($urandom));
        n++;
        repeat ($urandom_range(2, 20)) begin
          case ($urandom_range(0, 15))
            0: it = rand_item();
            1: begin it = rand_item(); it.req_type = REQ_RELEASE; end
            2: begin it = rand_item(); it.req_type = REQ_STEAL; end
            3: begin
              it = rand_item(); it.req_type = REQ_LOAD;
              it.load_address = 14'($urandom_range(0, 63));
            end
            default: begin it = rand_item(); it.req_type = REQ_TICK; end
          endcase
          // random noise items stay on loaded frames and allowed regions
          if (it.req_type == REQ_LOAD) it.load_address = it.load_address % 64;
          if (it.req_type == REQ_START) it.region_start = it.region_start % 64;
          send(it);
          n++;
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("** sample_voice_player_core: PASSED **");
    else $display("** sample_voice_player_core: FAILED **");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/svp_pkg.sv
src/svp_if.sv
src/svp_store.sv
src/svp_seq.sv
src/sample_voice_player_core.sv
src/svp_checker.sv
tb/sv/svp_tb_checker.sv
tb/sv/tb_sample_voice_player_core.sv
